@@ src/multi_queue_stable_priority_queue_macros.svh @@
// assertion helpers for the checker
`ifndef MULTI_QUEUE_STABLE_PRIORITY_QUEUE_MACROS_SVH
`define MULTI_QUEUE_STABLE_PRIORITY_QUEUE_MACROS_SVH

// checked outside reset only
`define MQSPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define MQSPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mqspq_pkg.sv @@
`default_nettype none
package mqspq_pkg;

  localparam int NUM_QUEUES   = 5;
  localparam int QUEUE_DEPTH  = 16;
  localparam int JOB_BITS     = 16;
  localparam int OUT_JOB_BITS = 16;

  localparam int SLOT_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_BITS = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int ADDR_BITS = QIDX_BITS + SLOT_BITS;
  localparam int MEM_DEPTH = NUM_QUEUES * (1 << SLOT_BITS);

  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = 1;
  localparam int FIFO_CNT_BITS = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic       command;
    logic [2:0] printer;
    logic [3:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [OUT_JOB_BITS-1:0] job_number;
  } out_item_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic                 command;
    logic [QIDX_BITS-1:0] queue;
    logic [3:0]           prio;
    logic [JOB_BITS-1:0]  job;
  } cmd_t;

  typedef struct packed {
    logic [3:0]          prio;
    logic [JOB_BITS-1:0] job;
  } slot_t;

  function automatic logic [ADDR_BITS-1:0] mk_addr(logic [QIDX_BITS-1:0] q,
                                                   logic [SLOT_BITS-1:0] s);
    return {q, s};
  endfunction

  function automatic logic [OUT_JOB_BITS-1:0] job_to_out(logic [JOB_BITS-1:0] j);
    logic [JOB_BITS+OUT_JOB_BITS-1:0] w;
    w = {{OUT_JOB_BITS{1'b0}}, j};
    return w[OUT_JOB_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/mqspq_fifo.sv @@
`default_nettype none
module mqspq_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mqspq_pkg::cmd_t push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output mqspq_pkg::cmd_t      head
);

  mqspq_pkg::cmd_t                         buf_r [mqspq_pkg::FIFO_DEPTH];
  logic [mqspq_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mqspq_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mqspq_pkg::FIFO_CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic                                    do_push, do_pop;

  assign full  = (cnt_r == mqspq_pkg::FIFO_CNT_BITS'(mqspq_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = buf_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ src/mqspq_front.sv @@
`default_nettype none
module mqspq_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire mqspq_pkg::in_item_t in_data,
  input  wire logic                fifo_full,
  output logic                     busy,
  output logic                     push,
  output mqspq_pkg::cmd_t          push_data
);

  logic [mqspq_pkg::JOB_BITS-1:0] job_r, job_nxt;
  logic                           accept;
  logic                           q_valid;
  logic [7:0]                     q_wide;

  assign busy   = fifo_full;
  assign accept = start && !fifo_full;

  assign q_valid = (in_data.printer != 3'd0) &&
                   (32'(in_data.printer) <= mqspq_pkg::NUM_QUEUES);
  assign q_wide  = 8'(in_data.printer) - 8'd1;

  // job numbers are taken by every enqueue, valid queue or not
  always_comb begin
    job_nxt = job_r;
    if (accept && in_data.command == mqspq_pkg::CMD_ENQ) begin
      job_nxt = (job_r == '1) ? mqspq_pkg::JOB_BITS'(1) : job_r + 1'b1;
    end
  end

  assign push              = accept && q_valid;
  assign push_data.command = in_data.command;
  assign push_data.queue   = q_wide[mqspq_pkg::QIDX_BITS-1:0];
  assign push_data.prio    = in_data.priority_req;
  assign push_data.job     = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= mqspq_pkg::JOB_BITS'(1);
    end else begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/mqspq_back.sv @@
`default_nettype none
module mqspq_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fifo_empty,
  input  wire mqspq_pkg::cmd_t head,
  output logic                 pop,
  output logic                 out_strobe,
  output mqspq_pkg::out_item_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_INS0 = 3'd2;
  localparam logic [2:0] S_DQH  = 3'd3;
  localparam logic [2:0] S_DQS  = 3'd4;

  localparam int SB = mqspq_pkg::SLOT_BITS;
  localparam int CB = mqspq_pkg::CNT_BITS;

  logic [2:0]                        state_r, state_nxt;
  mqspq_pkg::cmd_t                   item_r, item_nxt;
  logic [SB-1:0]                     idx_r, idx_nxt;
  logic [CB-1:0]                     len_r, len_nxt;
  logic [CB-1:0]                     cnt_r [mqspq_pkg::NUM_QUEUES];
  logic [CB-1:0]                     cnt_nxt [mqspq_pkg::NUM_QUEUES];
  logic                              out_valid_r, out_valid_nxt;
  mqspq_pkg::out_item_t              out_data_r, out_data_nxt;

  mqspq_pkg::slot_t                  mem [mqspq_pkg::MEM_DEPTH];
  mqspq_pkg::slot_t                  rd_data_r;
  logic [mqspq_pkg::ADDR_BITS-1:0]   ra, wa;
  logic                              we;
  mqspq_pkg::slot_t                  wd;

  logic [CB-1:0]                     head_cnt;
  logic [CB-1:0]                     head_cm1;
  logic [CB:0]                       idx_p2;

  assign head_cnt = cnt_r[head.queue];
  assign head_cm1 = head_cnt - 1'b1;
  assign idx_p2   = (CB + 1)'(idx_r) + (CB + 1)'(2);

  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    ra            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (!fifo_empty) begin
          pop      = 1'b1;
          item_nxt = head;
          len_nxt  = head_cnt;
          if (head.command == mqspq_pkg::CMD_ENQ) begin
            if (head_cnt == CB'(mqspq_pkg::QUEUE_DEPTH)) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.status     = mqspq_pkg::STATUS_FULL;
              out_data_nxt.job_number = '0;
            end else if (head_cnt == '0) begin
              we                    = 1'b1;
              wa                    = mqspq_pkg::mk_addr(head.queue, '0);
              wd                    = '{prio: head.prio, job: head.job};
              cnt_nxt[head.queue]   = CB'(1);
            end else begin
              // walk from the tail, one slot a cycle
              ra                  = mqspq_pkg::mk_addr(head.queue, head_cm1[SB-1:0]);
              idx_nxt             = head_cnt[SB-1:0];
              cnt_nxt[head.queue] = head_cnt + 1'b1;
              state_nxt           = S_INS;
            end
          end else begin
            if (head_cnt == '0) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.status     = mqspq_pkg::STATUS_EMPTY;
              out_data_nxt.job_number = '0;
            end else begin
              ra                  = mqspq_pkg::mk_addr(head.queue, '0);
              cnt_nxt[head.queue] = head_cm1;
              state_nxt           = S_DQH;
            end
          end
        end
      end
      S_INS: begin
        we = 1'b1;
        wa = mqspq_pkg::mk_addr(item_r.queue, idx_r);
        // equal priority stays ahead: insert after it
        if (rd_data_r.prio >= item_r.prio) begin
          wd        = '{prio: item_r.prio, job: item_r.job};
          state_nxt = S_IDLE;
        end else begin
          wd = rd_data_r;
          if (idx_r == SB'(1)) begin
            state_nxt = S_INS0;
          end else begin
            idx_nxt = idx_r - 1'b1;
            ra      = mqspq_pkg::mk_addr(item_r.queue, idx_r - SB'(2));
          end
        end
      end
      S_INS0: begin
        we        = 1'b1;
        wa        = mqspq_pkg::mk_addr(item_r.queue, '0);
        wd        = '{prio: item_r.prio, job: item_r.job};
        state_nxt = S_IDLE;
      end
      S_DQH: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.status     = mqspq_pkg::STATUS_OK;
        out_data_nxt.job_number = mqspq_pkg::job_to_out(rd_data_r.job);
        if (len_r == CB'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          ra        = mqspq_pkg::mk_addr(item_r.queue, SB'(1));
          idx_nxt   = '0;
          state_nxt = S_DQS;
        end
      end
      S_DQS: begin
        we = 1'b1;
        wa = mqspq_pkg::mk_addr(item_r.queue, idx_r);
        wd = rd_data_r;
        if (idx_p2 == (CB + 1)'(len_r)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          ra      = mqspq_pkg::mk_addr(item_r.queue, idx_p2[SB-1:0]);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mqspq_pkg::NUM_QUEUES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
  end

  // slot store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

endmodule
`default_nettype wire

@@ src/multi_queue_stable_priority_queue.sv @@
// Five job queues served by priority, oldest first among equals. An item is taken at
// a rising edge with start high and busy low; a result appears for exactly one cycle
// with out_strobe high and must be captured then, as nothing holds it. Accepted items
// wait in a two-entry queue and busy is high while that queue is full. Items on an
// invalid queue and enqueues that land in a free slot give no result. The back end
// settles an enqueue into an empty or full queue or a dequeue of an empty queue in
// its idle state; an ordered enqueue walks from the tail, moving each lower-priority
// entry back a slot (at most QUEUE_DEPTH - 1) before writing the new one; a dequeue
// returns the head and shifts the rest forward. It takes the next item only once the
// last is done. The slot memory has one write port and one registered read port and
// so moves one slot per cycle; it starts undefined and needs no clearing after reset.
`default_nettype none
module multi_queue_stable_priority_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire mqspq_pkg::in_item_t in_data,
  output logic                     out_strobe,
  output mqspq_pkg::out_item_t     out_data
);

  logic            push, pop, fifo_full, fifo_empty;
  mqspq_pkg::cmd_t push_data, head;

  mqspq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  mqspq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (fifo_full),
    .empty     (fifo_empty),
    .head      (head)
  );

  mqspq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

@@ src/mqspq_checker.sv @@
`default_nettype none
`include "multi_queue_stable_priority_queue_macros.svh"
module mqspq_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_strobe,
  input wire mqspq_pkg::out_item_t out_data
);

  logic res_ok, res_other, job_zero, beat_in;

  assign res_ok    = out_strobe && (out_data.status == mqspq_pkg::STATUS_OK);
  assign res_other = out_strobe && (out_data.status != mqspq_pkg::STATUS_OK);
  assign job_zero  = (out_data.job_number == '0);
  assign beat_in   = start && !busy;

  // a status other than returned always carries a zero job number
  `MQSPQ_ASSERT(a_nojob_zero, clk, rst_n, res_other |-> job_zero, "stray job number")

  // zero is never issued as a job number
  `MQSPQ_ASSERT(a_job_nonzero, clk, rst_n, res_ok |-> !job_zero, "job number zero")

  // busy only rises after a beat went in
  `MQSPQ_ASSERT(a_busy_cause, clk, rst_n, $rose(busy) |-> $past(beat_in), "busy rose unprompted")

  `MQSPQ_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_strobe && !busy, "activity after reset")

endmodule

bind multi_queue_stable_priority_queue mqspq_checker u_mqspq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;

  localparam int unsigned CYCLE_LIMIT = 1200000;
  // two items may sit in the input queue
  localparam int SETTLE_CYCLES = 2 * (mqspq_pkg::QUEUE_DEPTH + 3) + 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  mqspq_pkg::in_item_t  in_data = '0;
  logic                 out_strobe;
  mqspq_pkg::out_item_t out_data;

  multi_queue_stable_priority_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // shadow copy of the queues, kept in service order
  logic [3:0]                    shadow_prio [mqspq_pkg::NUM_QUEUES][mqspq_pkg::QUEUE_DEPTH];
  logic [mqspq_pkg::JOB_BITS-1:0] shadow_job [mqspq_pkg::NUM_QUEUES][mqspq_pkg::QUEUE_DEPTH];
  int                            shadow_fill [mqspq_pkg::NUM_QUEUES];
  logic [mqspq_pkg::JOB_BITS-1:0] job_counter;
  mqspq_pkg::out_item_t          pending_results [$];

  int          error_count = 0;
  int          items_sent = 0;
  int          sender_idle_pct = 0;
  int unsigned cycle_count = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic void predict_queue_op(input mqspq_pkg::in_item_t it);
    logic [mqspq_pkg::JOB_BITS-1:0] job;
    int                             q;
    int                             pos;
    int                             i;
    mqspq_pkg::out_item_t           r;
    bit                             valid_q;
    valid_q = (it.printer >= 1) && (it.printer <= mqspq_pkg::NUM_QUEUES);
    q = int'(it.printer) - 1;
    if (it.command == mqspq_pkg::CMD_ENQ) begin
      job = job_counter;
      job_counter = (job_counter == '1) ? mqspq_pkg::JOB_BITS'(1) : job_counter + 1'b1;
      if (!valid_q) return;
      if (shadow_fill[q] >= mqspq_pkg::QUEUE_DEPTH) begin
        r.status = mqspq_pkg::STATUS_FULL;
        r.job_number = '0;
        pending_results.push_back(r);
        return;
      end
      // new job goes behind every entry of equal or higher priority
      pos = 0;
      while (pos < shadow_fill[q] && shadow_prio[q][pos] >= it.priority_req) pos++;
      for (i = shadow_fill[q]; i > pos; i--) begin
        shadow_prio[q][i] = shadow_prio[q][i-1];
        shadow_job[q][i] = shadow_job[q][i-1];
      end
      shadow_prio[q][pos] = it.priority_req;
      shadow_job[q][pos] = job;
      shadow_fill[q]++;
    end else begin
      if (!valid_q) return;
      if (shadow_fill[q] == 0) begin
        r.status = mqspq_pkg::STATUS_EMPTY;
        r.job_number = '0;
        pending_results.push_back(r);
        return;
      end
      r.status = mqspq_pkg::STATUS_OK;
      r.job_number = shadow_job[q][0];
      pending_results.push_back(r);
      for (i = 0; i + 1 < shadow_fill[q]; i++) begin
        shadow_prio[q][i] = shadow_prio[q][i+1];
        shadow_job[q][i] = shadow_job[q][i+1];
      end
      shadow_fill[q]--;
    end
  endfunction

  // called just after a rising edge; start stays high when it returns
  task automatic send_item(input mqspq_pkg::in_item_t it);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_op(it);
    items_sent++;
  endtask

  task automatic issue(input logic cmd, input logic [2:0] printer, input logic [3:0] prio);
    mqspq_pkg::in_item_t it;
    it.command = cmd;
    it.printer = printer;
    it.priority_req = prio;
    send_item(it);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_prio();
    if ($urandom_range(99) < 80) return 4'($urandom_range(1, 10));
    return 4'($urandom_range(0, 15));
  endfunction

  always @(posedge clk) begin
    mqspq_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status %0d job %0d",
                                  out_data.status, out_data.job_number));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want.status));
        if (out_data.job_number !== want.job_number)
          report_mismatch($sformatf("job_number got %0d want %0d",
                                    out_data.job_number, want.job_number));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[multi_queue_stable_priority_queue] ERROR");
      $finish;
    end
  end

  task automatic test_basic_ops();
    issue(mqspq_pkg::CMD_DEQ, 3'd1, 4'd0);     // empty queue
    issue(mqspq_pkg::CMD_DEQ, 3'd0, 4'd15);    // invalid queues, ignored
    issue(mqspq_pkg::CMD_DEQ, 3'd6, 4'd3);
    issue(mqspq_pkg::CMD_DEQ, 3'd7, 4'd9);
    issue(mqspq_pkg::CMD_ENQ, 3'd0, 4'd5);     // dropped but numbered
    issue(mqspq_pkg::CMD_ENQ, 3'd7, 4'd15);
    issue(mqspq_pkg::CMD_ENQ, 3'd1, 4'd15);
    issue(mqspq_pkg::CMD_ENQ, 3'd1, 4'd0);
    issue(mqspq_pkg::CMD_ENQ, 3'd1, 4'd15);    // tie, must follow the first one
    issue(mqspq_pkg::CMD_ENQ, 3'd1, 4'd7);
    issue(mqspq_pkg::CMD_ENQ, 3'd5, 4'd10);
    repeat (4) issue(mqspq_pkg::CMD_DEQ, 3'd1, 4'd0);
    issue(mqspq_pkg::CMD_DEQ, 3'd1, 4'd15);
    issue(mqspq_pkg::CMD_DEQ, 3'd5, 4'd0);
    issue(mqspq_pkg::CMD_DEQ, 3'd5, 4'd0);
    wait_drained();
  endtask

  task automatic test_full_queue();
    repeat (mqspq_pkg::QUEUE_DEPTH)
      issue(mqspq_pkg::CMD_ENQ, 3'd4, 4'($urandom_range(0, 15)));
    issue(mqspq_pkg::CMD_ENQ, 3'd4, 4'd15);    // full
    issue(mqspq_pkg::CMD_ENQ, 3'd4, 4'd0);
    repeat (mqspq_pkg::QUEUE_DEPTH + 1) issue(mqspq_pkg::CMD_DEQ, 3'd4, 4'd0);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle_pct, input int count);
    int target;
    int qn;
    target = items_sent + count;
    sender_idle_pct = idle_pct;
    while (items_sent < target) begin
      if ($urandom_range(99) < 70) begin
        qn = $urandom_range(1, mqspq_pkg::NUM_QUEUES);
        repeat ($urandom_range(1, mqspq_pkg::QUEUE_DEPTH + 2))
          issue(mqspq_pkg::CMD_ENQ, 3'(qn), pick_prio());
        repeat ($urandom_range(1, mqspq_pkg::QUEUE_DEPTH + 2))
          issue(mqspq_pkg::CMD_DEQ, 3'(qn), pick_prio());
      end else begin
        issue(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      end
    end
    wait_drained();
    sender_idle_pct = 0;
  endtask

  initial begin
    for (int q = 0; q < mqspq_pkg::NUM_QUEUES; q++) shadow_fill[q] = 0;
    job_counter = mqspq_pkg::JOB_BITS'(1);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_full_queue();
    test_random_phase(0, 480);
    test_random_phase(50, 480);
    test_random_phase(0, 480);
    test_random_phase(24, 480);
    if (error_count == 0) begin
      $display("[multi_queue_stable_priority_queue] OK");
    end else begin
      $display("[multi_queue_stable_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ multi_queue_stable_priority_queue.f @@
+incdir+src
src/mqspq_pkg.sv
src/mqspq_fifo.sv
src/mqspq_front.sv
src/mqspq_back.sv
src/multi_queue_stable_priority_queue.sv
src/mqspq_checker.sv
tb/testbench.sv
